// ===== hdl/thil_pkg.sv =====
// Package for the timed history lookup: payload types, constants and codes.
package thil_pkg;

    localparam int unsigned HISTORY_DEPTH_DEF = 64;
    localparam logic [31:0] RECORD_WINDOW_RST = 32'd4000000;
    localparam logic        ACT_RECORD = 1'b0;
    localparam logic        ACT_QUERY  = 1'b1;
    localparam logic [16:0] FRAC_ONE   = 17'h10000;

    typedef struct packed {
        logic        action;
        logic [31:0] stamp_time;
        logic        teleported;
        logic signed [31:0] min_x;
        logic signed [31:0] min_y;
        logic signed [31:0] min_z;
        logic signed [31:0] max_x;
        logic signed [31:0] max_y;
        logic signed [31:0] max_z;
    } req_t;

    typedef struct packed {
        logic        found;
        logic [31:0] frame_time;
        logic        frame_teleported;
        logic signed [31:0] out_min_x;
        logic signed [31:0] out_min_y;
        logic signed [31:0] out_min_z;
        logic signed [31:0] out_max_x;
        logic signed [31:0] out_max_y;
        logic signed [31:0] out_max_z;
    } rsp_t;

    // One stored frame: flag and six coordinates, time kept apart.
    typedef struct packed {
        logic        flag;
        logic [5:0][31:0] box;
    } frame_t;

endpackage

// ===== hdl/thil_div.sv =====
// Restoring divider producing a 17-bit quotient of (num << 16) / den, one bit per cycle.
module thil_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] num,
    input  logic [31:0] den,
    output logic        done,
    output logic [16:0] quot
);
    logic [32:0] rem_reg, rem_next;
    logic [47:0] nsh_reg, nsh_next;
    logic [31:0] den_reg, den_next;
    logic [16:0] q_reg, q_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        run_reg, run_next;
    logic        done_reg, done_next;
    logic [32:0] trial;
    logic [33:0] diff;

    always_comb
    begin
        rem_next  = rem_reg;
        nsh_next  = nsh_reg;
        den_next  = den_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        trial     = {rem_reg[31:0], nsh_reg[47]};
        diff      = {1'b0, trial} - {2'b00, den_reg};
        if (start)
        begin
            rem_next = '0;
            nsh_next = {num, 16'h0000};
            den_next = den;
            q_next   = '0;
            cnt_next = 6'd48;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            nsh_next = {nsh_reg[46:0], 1'b0};
            if (!diff[33])
            begin
                rem_next = diff[32:0];
                q_next   = (q_reg == 17'h1ffff) ? q_reg : {q_reg[15:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                q_next   = {q_reg[15:0], 1'b0};
            end
            // A quotient above one is clamped later; only low 17 bits matter after a guard.
            if (!diff[33] && q_reg[16]) q_next = 17'h1ffff;
            else if (q_reg[16]) q_next = 17'h1ffff;
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        nsh_reg <= nsh_next;
        den_reg <= den_next;
        q_reg   <= q_next;
    end

    assign done = done_reg;
    assign quot = q_reg;
endmodule

// ===== hdl/timed_history_interp_lookup_core.sv =====
// Top level of the timed frame history with interpolated lookup.
// A request is taken when start is high and busy is low; busy then stays high until the
// request is finished, and the next request may be taken in the first cycle busy is low.
// A record skips the trim when fewer than two frames are held; otherwise it trims old
// frames one at a time, since the trim walks the ring through the single time-memory read
// port, and then pushes. A query walks back one frame at a time from the newest (up to
// HISTORY_DEPTH - 1 frames); an empty history answers from S_QOLD and a query older than
// the oldest frame from S_QCHK. An interpolated query adds the bit-serial divider and the
// shared 33x18 multiplier: the older frame is fetched first, then each coordinate takes a
// multiply step and an accumulate step. Each query result appears on result for exactly one
// cycle with result_valid high, in the first cycle that busy is low, and cannot be held off;
// records give none. Ring slots wrap at HISTORY_DEPTH, which need not be a power of two.
module timed_history_interp_lookup_core #(
    parameter int unsigned HISTORY_DEPTH = thil_pkg::HISTORY_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  thil_pkg::req_t   request,
    output logic             result_valid,
    output thil_pkg::rsp_t   result,
    input  logic             cfg_we,
    input  logic [31:0]      cfg_wdata
);
    localparam int unsigned AW = $clog2(HISTORY_DEPTH);
    localparam int unsigned CW = $clog2(HISTORY_DEPTH + 1);
    localparam logic [AW:0] DEPTH_W = (AW + 1)'(HISTORY_DEPTH);
    localparam logic [AW-1:0] LAST_SLOT = AW'(HISTORY_DEPTH - 1);
    localparam logic [AW:0] ONE_W = (AW + 1)'(1);
    localparam logic [AW:0] TWO_W = (AW + 1)'(2);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_TRIMR = 4'd1;
    localparam logic [3:0] S_TRIMC = 4'd2;
    localparam logic [3:0] S_PUSH  = 4'd3;
    localparam logic [3:0] S_QOLD  = 4'd4;
    localparam logic [3:0] S_QCHK  = 4'd5;
    localparam logic [3:0] S_WALK  = 4'd6;
    localparam logic [3:0] S_DEC   = 4'd7;
    localparam logic [3:0] S_FRM   = 4'd8;
    localparam logic [3:0] S_DIV   = 4'd9;
    localparam logic [3:0] S_MUL   = 4'd10;
    localparam logic [3:0] S_ACC   = 4'd11;
    localparam logic [3:0] S_OUT   = 4'd12;

    // Slot that lies off places behind base, wrapping at the ring depth.
    function automatic logic [AW-1:0] wrap_back(input logic [AW-1:0] base,
                                                input logic [AW:0] off);
        logic [AW:0] b;
        logic [AW:0] d;
        b = {1'b0, base};
        if (b >= off)
            d = b - off;
        else
            d = b + DEPTH_W - off;
        return d[AW-1:0];
    endfunction

    logic [3:0]    st_reg, st_next;
    logic [31:0]   win_reg;
    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] k_reg, k_next;
    thil_pkg::req_t req_reg;
    logic [31:0]   newest_t_reg, newest_t_next;
    logic [31:0]   oldest_t_reg, oldest_t_next;
    logic [31:0]   older_t_reg, older_t_next;
    logic [31:0]   young_t_reg, young_t_next;
    logic [AW-1:0] young_s_reg, young_s_next;
    logic [AW-1:0] older_s_reg, older_s_next;
    logic [16:0]   frac_reg, frac_next;
    logic [2:0]    ci_reg, ci_next;
    logic          phase_reg, phase_next;
    logic          fa_reg, fa_next;
    thil_pkg::frame_t fa_frm_reg, fa_frm_next;
    logic signed [49:0] prod_reg, prod_next;
    thil_pkg::rsp_t rsp_reg, rsp_next;
    logic          rv_reg, rv_next;

    // Memories.
    logic [31:0]      tmem [HISTORY_DEPTH];
    thil_pkg::frame_t fmem [HISTORY_DEPTH];
    logic [AW-1:0]    t_addr;
    logic [31:0]      t_rd;
    logic [AW-1:0]    f_addr;
    thil_pkg::frame_t f_rd;
    logic             mem_we;

    logic          div_start, div_done;
    logic [16:0]   div_q;
    logic [31:0]   div_num, div_den;

    logic [AW-1:0] slot_k1;
    logic [AW-1:0] slot_k2;
    logic [AW-1:0] slot_old;
    logic signed [32:0] diff_c;
    logic signed [32:0] span;
    logic [AW:0]   cnt_ext;
    logic [AW:0]   k_ext;
    logic signed [31:0] a_c, b_c;
    logic signed [50:0] rounded;
    logic signed [31:0] res_c;

    assign cnt_ext  = (AW + 1)'(cnt_reg);
    assign k_ext    = (AW + 1)'(k_reg);
    assign slot_k1  = wrap_back(head_reg, k_ext + ONE_W);
    assign slot_k2  = wrap_back(head_reg, k_ext + TWO_W);
    assign slot_old = wrap_back(head_reg, cnt_ext - ONE_W);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            tmem[head_next] <= req_reg.stamp_time;
            fmem[head_next] <= {req_reg.teleported, req_reg.max_z, req_reg.max_y,
                                req_reg.max_x, req_reg.min_z, req_reg.min_y, req_reg.min_x};
        end
        t_rd <= tmem[t_addr];
        f_rd <= fmem[f_addr];
    end

    thil_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_q)
    );

    assign div_num = req_reg.stamp_time - older_t_reg;
    assign div_den = young_t_reg - older_t_reg;

    always_comb
    begin
        st_next       = st_reg;
        head_next     = head_reg;
        cnt_next      = cnt_reg;
        k_next        = k_reg;
        newest_t_next = newest_t_reg;
        oldest_t_next = oldest_t_reg;
        older_t_next  = older_t_reg;
        young_t_next  = young_t_reg;
        young_s_next  = young_s_reg;
        older_s_next  = older_s_reg;
        frac_next     = frac_reg;
        ci_next       = ci_reg;
        phase_next    = phase_reg;
        fa_next       = fa_reg;
        fa_frm_next   = fa_frm_reg;
        prod_next     = prod_reg;
        rsp_next      = rsp_reg;
        rv_next       = 1'b0;
        mem_we        = 1'b0;
        div_start     = 1'b0;
        t_addr        = slot_old;
        f_addr        = older_s_reg;
        span          = $signed({1'b0, newest_t_reg}) - $signed({1'b0, t_rd});
        diff_c        = '0;
        a_c           = '0;
        b_c           = '0;
        rounded       = '0;
        res_c         = '0;
        unique case (st_reg)
            S_IDLE:
            begin
                t_addr = head_reg;
                if (start)
                begin
                    rsp_next = '0;
                    st_next  = (request.action == thil_pkg::ACT_QUERY) ? S_QOLD : S_TRIMR;
                end
            end
            S_TRIMR:
            begin
                // Newest time is read now; the oldest is addressed for the next cycle.
                newest_t_next = t_rd;
                t_addr        = slot_old;
                st_next       = (cnt_reg >= CW'(2)) ? S_TRIMC : S_PUSH;
            end
            S_TRIMC:
            begin
                if (!span[32] && span > $signed({1'b0, win_reg}) && cnt_reg > CW'(1))
                begin
                    cnt_next = cnt_reg - CW'(1);
                    t_addr   = wrap_back(head_reg, cnt_ext - TWO_W);
                end
                else
                    st_next = S_PUSH;
            end
            S_PUSH:
            begin
                head_next = (head_reg == LAST_SLOT) ? '0 : head_reg + AW'(1);
                if (cnt_ext < DEPTH_W) cnt_next = cnt_reg + CW'(1);
                mem_we  = 1'b1;
                st_next = S_IDLE;
            end
            S_QOLD:
            begin
                newest_t_next = t_rd;
                t_addr        = slot_old;
                k_next        = '0;
                if (cnt_reg == '0)
                begin
                    rv_next = 1'b1;
                    st_next = S_IDLE;
                end
                else
                    st_next = S_QCHK;
            end
            S_QCHK:
            begin
                oldest_t_next = t_rd;
                older_t_next  = newest_t_reg;
                young_t_next  = newest_t_reg;
                older_s_next  = head_reg;
                young_s_next  = head_reg;
                t_addr        = wrap_back(head_reg, ONE_W);
                if (t_rd > req_reg.stamp_time)
                begin
                    rv_next = 1'b1;
                    st_next = S_IDLE;
                end
                else
                    st_next = S_WALK;
            end
            S_WALK:
            begin
                // older_t holds the time at k; t_rd holds the time at k+1.
                t_addr = slot_k2;
                if (older_t_reg > req_reg.stamp_time && k_reg + CW'(1) < cnt_reg)
                begin
                    k_next       = k_reg + CW'(1);
                    older_t_next = t_rd;
                    older_s_next = slot_k1;
                    if (t_rd > req_reg.stamp_time)
                    begin
                        young_t_next = t_rd;
                        young_s_next = slot_k1;
                    end
                end
                else
                    st_next = S_DEC;
            end
            S_DEC:
            begin
                f_addr = older_s_reg;
                if (older_t_reg == req_reg.stamp_time)
                    st_next = S_FRM;
                else if (newest_t_reg <= req_reg.stamp_time)
                begin
                    f_addr       = head_reg;
                    older_t_next = newest_t_reg;
                    st_next      = S_FRM;
                end
                else if (oldest_t_reg == req_reg.stamp_time)
                begin
                    f_addr       = slot_old;
                    older_t_next = oldest_t_reg;
                    st_next      = S_FRM;
                end
                else
                begin
                    div_start = 1'b1;
                    st_next   = S_DIV;
                end
            end
            S_FRM:
            begin
                rsp_next.found            = 1'b1;
                rsp_next.frame_time       = older_t_reg;
                rsp_next.frame_teleported = f_rd.flag;
                rsp_next.out_min_x        = f_rd.box[0];
                rsp_next.out_min_y        = f_rd.box[1];
                rsp_next.out_min_z        = f_rd.box[2];
                rsp_next.out_max_x        = f_rd.box[3];
                rsp_next.out_max_y        = f_rd.box[4];
                rsp_next.out_max_z        = f_rd.box[5];
                rv_next = 1'b1;
                st_next = S_IDLE;
            end
            S_DIV:
            begin
                f_addr = older_s_reg;
                if (div_done)
                begin
                    if (div_den == '0) frac_next = '0;
                    else if (div_q > thil_pkg::FRAC_ONE) frac_next = thil_pkg::FRAC_ONE;
                    else frac_next = div_q;
                    ci_next    = '0;
                    phase_next = 1'b0;
                    st_next    = S_MUL;
                end
            end
            S_MUL:
            begin
                // First pass latches older frame, then young frame reads follow.
                f_addr = young_s_reg;
                if (!phase_reg)
                begin
                    fa_frm_next = f_rd;
                    phase_next  = 1'b1;
                end
                else
                begin
                    a_c       = fa_frm_reg.box[ci_reg];
                    b_c       = f_rd.box[ci_reg];
                    diff_c    = 33'(b_c) - 33'(a_c);
                    prod_next = 50'(diff_c) * $signed({1'b0, frac_reg});
                    fa_next   = fa_frm_reg.flag | f_rd.flag;
                    st_next   = S_ACC;
                end
            end
            S_ACC:
            begin
                f_addr  = young_s_reg;
                a_c     = fa_frm_reg.box[ci_reg];
                rounded = 51'(prod_reg) + 51'sd32768;
                res_c   = a_c + 32'(rounded >>> 16);
                unique case (ci_reg)
                    3'd0:    rsp_next.out_min_x = res_c;
                    3'd1:    rsp_next.out_min_y = res_c;
                    3'd2:    rsp_next.out_min_z = res_c;
                    3'd3:    rsp_next.out_max_x = res_c;
                    3'd4:    rsp_next.out_max_y = res_c;
                    default: rsp_next.out_max_z = res_c;
                endcase
                if (ci_reg == 3'd5)
                    st_next = S_OUT;
                else
                begin
                    ci_next = ci_reg + 3'd1;
                    st_next = S_MUL;
                end
            end
            S_OUT:
            begin
                rsp_next.found            = 1'b1;
                rsp_next.frame_time       = req_reg.stamp_time;
                rsp_next.frame_teleported = fa_reg;
                rv_next = 1'b1;
                st_next = S_IDLE;
            end
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= S_IDLE;
            win_reg  <= thil_pkg::RECORD_WINDOW_RST;
            head_reg <= '0;
            cnt_reg  <= '0;
            rv_reg   <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            head_reg <= head_next;
            cnt_reg  <= cnt_next;
            rv_reg   <= rv_next;
            if (cfg_we) win_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_reg == S_IDLE && start) req_reg <= request;
        k_reg        <= k_next;
        newest_t_reg <= newest_t_next;
        oldest_t_reg <= oldest_t_next;
        older_t_reg  <= older_t_next;
        young_t_reg  <= young_t_next;
        young_s_reg  <= young_s_next;
        older_s_reg  <= older_s_next;
        frac_reg     <= frac_next;
        ci_reg       <= ci_next;
        phase_reg    <= phase_next;
        fa_reg       <= fa_next;
        fa_frm_reg   <= fa_frm_next;
        prod_reg     <= prod_next;
        rsp_reg      <= rsp_next;
    end

    assign busy         = (st_reg != S_IDLE);
    assign result_valid = rv_reg;
    assign result       = rsp_reg;
endmodule

// ===== dv/tb_top.sv =====
// Testbench for the timed frame history lookup: table-driven directed requests, then random.
`timescale 1ns / 1ps

module tb_top;
    localparam int unsigned DEPTH = thil_pkg::HISTORY_DEPTH_DEF;
    localparam logic REC = thil_pkg::ACT_RECORD;
    localparam logic QRY = thil_pkg::ACT_QUERY;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    thil_pkg::req_t request = '0;
    logic result_valid;
    thil_pkg::rsp_t result;
    logic cfg_we = 1'b0;
    logic [31:0] cfg_wdata = '0;

    timed_history_interp_lookup_core i_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .request(request),
        .result_valid(result_valid), .result(result), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    always #5 clk = ~clk;

    // Predictor state.
    logic [31:0] win_us;
    logic [31:0] ring_time [DEPTH];
    logic        ring_flag [DEPTH];
    logic [5:0][31:0] ring_box [DEPTH];
    int unsigned head_idx;
    int unsigned held;

    thil_pkg::rsp_t lookups_due[$];
    int   error_count = 0;
    bit   idle_on = 1'b1;

    function automatic int unsigned back_slot(int unsigned k);
        return (head_idx + DEPTH - (k % DEPTH)) % DEPTH;
    endfunction

    function automatic thil_pkg::rsp_t frame_at(int unsigned s);
        thil_pkg::rsp_t r;
        r = '0;
        r.found = 1'b1;
        r.frame_time = ring_time[s];
        r.frame_teleported = ring_flag[s];
        {r.out_min_x, r.out_min_y, r.out_min_z, r.out_max_x, r.out_max_y, r.out_max_z}
            = ring_box[s];
        return r;
    endfunction

    function automatic void push_frame(thil_pkg::req_t q);
        longint span;
        while (held > 1)
        begin
            span = longint'(ring_time[head_idx]) - longint'(ring_time[back_slot(held - 1)]);
            if (span <= longint'(win_us)) break;
            held--;
        end
        head_idx = (head_idx + 1) % DEPTH;
        if (held < DEPTH) held++;
        ring_time[head_idx] = q.stamp_time;
        ring_flag[head_idx] = q.teleported;
        ring_box[head_idx] = {q.min_x, q.min_y, q.min_z, q.max_x, q.max_y, q.max_z};
    endfunction

    function automatic thil_pkg::rsp_t lookup_frame(logic [31:0] t);
        thil_pkg::rsp_t r;
        int unsigned oldest, older, younger, k;
        longint num, den, f, a, b, v;
        logic [5:0][31:0] box;
        r = '0;
        if (held == 0) return r;
        oldest = back_slot(held - 1);
        if (ring_time[oldest] > t) return r;
        younger = head_idx;
        older = head_idx;
        k = 0;
        while (ring_time[older] > t && k + 1 < held)
        begin
            k++;
            older = back_slot(k);
            if (ring_time[older] > t) younger = older;
        end
        if (ring_time[older] == t) return frame_at(older);
        if (ring_time[head_idx] <= t) return frame_at(head_idx);
        if (ring_time[oldest] == t) return frame_at(oldest);
        num = longint'(t) - longint'(ring_time[older]);
        den = longint'(ring_time[younger]) - longint'(ring_time[older]);
        f = 0;
        if (den > 0 && num > 0) f = (num <<< 16) / den;
        if (f > 65536) f = 65536;
        for (int i = 0; i < 6; i++)
        begin
            a = longint'(signed'(ring_box[older][i]));
            b = longint'(signed'(ring_box[younger][i]));
            v = (b - a) * f + 32768;
            v = a + (v >>> 16);
            box[i] = v[31:0];
        end
        r.found = 1'b1;
        r.frame_time = t;
        r.frame_teleported = ring_flag[older] | ring_flag[younger];
        {r.out_min_x, r.out_min_y, r.out_min_z, r.out_max_x, r.out_max_y, r.out_max_z} = box;
        return r;
    endfunction

    // Start drops only for an idle burst, drawn at random before a request while idle bursts are on.
    task automatic idle_gap();
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
    endtask

    // Issues one request; a query queues its prediction, or the given typed-in value.
    task automatic send_request(thil_pkg::req_t q, bit fixed, thil_pkg::rsp_t want);
        idle_gap();
        start <= 1'b1;
        request <= q;
        @(posedge clk);
        while (busy) @(posedge clk);
        if (q.action == QRY)
        begin
            if (fixed) lookups_due.push_back(want);
            else lookups_due.push_back(lookup_frame(q.stamp_time));
        end
        else push_frame(q);
        @(negedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (lookups_due.size() != 0) @(negedge clk);
        // Records give no result, so wait out a long trim walk.
        repeat (200) @(negedge clk);
    endtask

    task automatic set_window(logic [31:0] w);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= w;
        @(negedge clk);
        cfg_we <= 1'b0;
        win_us = w;
    endtask

    function automatic thil_pkg::req_t make_req(logic act, logic [31:0] t, logic tp,
                                                logic [31:0] c0, logic [31:0] c1);
        thil_pkg::req_t q;
        q.action = act;
        q.stamp_time = t;
        q.teleported = tp;
        q.min_x = c0; q.min_y = c1; q.min_z = ~c0;
        q.max_x = ~c1; q.max_y = c0 ^ c1; q.max_z = c0 + c1;
        return q;
    endfunction

    function automatic thil_pkg::req_t rand_req(logic act, logic [31:0] t);
        thil_pkg::req_t q;
        q = make_req(act, t, $urandom_range(0, 1), $urandom, $urandom);
        q.min_z = $urandom; q.max_x = $urandom; q.max_y = $urandom; q.max_z = $urandom;
        return q;
    endfunction

    always @(posedge clk)
    begin
        thil_pkg::rsp_t exp_r;
        if (rst_n && result_valid)
        begin
            if (lookups_due.size() == 0)
            begin
                error_count++;
                if (error_count <= 10) $display("unexpected result %h", result);
            end
            else
            begin
                exp_r = lookups_due.pop_front();
                if (result !== exp_r)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("mismatch: expected %h got %h", exp_r, result);
                end
            end
        end
    end

    typedef struct {
        thil_pkg::req_t q;
        bit   fixed;
        thil_pkg::rsp_t want;
    } stim_row_t;

    initial
    begin
        stim_row_t rows[$];
        thil_pkg::rsp_t none;
        thil_pkg::rsp_t top;
        logic [31:0] now;
        int n;
        none = '0;
        win_us = thil_pkg::RECORD_WINDOW_RST;
        head_idx = 0;
        held = 0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part: empty, extremes, exact hit, newer, too old, interpolation.
        top = '0;
        top.found = 1'b1;
        top.frame_time = 32'hFFFF_FFFF;
        top.frame_teleported = 1'b1;
        {top.out_min_x, top.out_min_y, top.out_min_z, top.out_max_x, top.out_max_y,
         top.out_max_z} = {32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                           32'hFFFF_FFFF, 32'hFFFF_FFFF};
        rows.push_back('{make_req(QRY, 0, 1, '1, '1), 1, none});
        rows.push_back('{make_req(QRY, '1, 0, 0, 0), 1, none});
        rows.push_back('{make_req(REC, 1000, 0, 32'h100, 32'hFFFF_FF00), 0, none});
        rows.push_back('{make_req(QRY, 999, 0, 0, 0), 1, none});
        rows.push_back('{make_req(QRY, 1000, 0, 0, 0), 0, none});
        rows.push_back('{make_req(REC, 3000, 1, 32'h7FFF_FFFF, 32'h8000_0000), 0, none});
        rows.push_back('{make_req(QRY, 2000, 0, 0, 0), 0, none});
        rows.push_back('{make_req(QRY, 1001, 0, 0, 0), 0, none});
        rows.push_back('{make_req(QRY, 2999, 0, 0, 0), 0, none});
        rows.push_back('{make_req(REC, 3000, 0, 32'h8000_0000, 0), 0, none});
        rows.push_back('{make_req(QRY, 3000, 1, 0, 0), 0, none});
        rows.push_back('{make_req(REC, 2500, 1, 32'h55, 32'hAA), 0, none});
        rows.push_back('{make_req(QRY, 2700, 0, 0, 0), 0, none});
        rows.push_back('{make_req(REC, '1, 1, 32'h8000_0000, 32'h7FFF_FFFF), 0, none});
        rows.push_back('{make_req(QRY, '1, 0, 0, 0), 1, top});
        rows.push_back('{make_req(QRY, 500, 0, 0, 0), 0, none});
        foreach (rows[i]) send_request(rows[i].q, rows[i].fixed, rows[i].want);

        // Random phases over several windows, extremes included.
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: set_window(32'd0);
                1: set_window(32'hFFFF_FFFF);
                2: set_window(32'd300);
                3: set_window(thil_pkg::RECORD_WINDOW_RST);
                4: set_window($urandom_range(1, 5000));
                default: set_window(32'd2000);
            endcase
            if (ph == 5) idle_on = 1'b0;
            now = (ph == 1) ? 32'hFFFF_0000 : $urandom_range(0, 1000);
            n = (ph == 1) ? 250 : 160;
            for (int i = 0; i < n; i++)
            begin
                int sel;
                sel = $urandom_range(0, 9);
                if (sel < 5)
                begin
                    // Mostly rising times, sometimes repeats or steps back.
                    if (sel == 0) now = now - $urandom_range(0, 200);
                    else if (sel != 1) now = now + $urandom_range(1, 400);
                    send_request(rand_req(REC, now), 0, none);
                end
                else if (sel == 9) send_request(rand_req(QRY, $urandom), 0, none);
                else send_request(rand_req(QRY, now - $urandom_range(0, 3000)), 0, none);
            end
        end
        drain();
        if (error_count == 0 && lookups_due.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("DONE: errors detected");
        $finish;
    end
endmodule
